// ===== rtl/core/lvb_pkg.sv =====
package lvb_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int DECAY_BITS    = 24;
  localparam int DEC_SHIFT     = DECAY_BITS - FRACTION_BITS;
  localparam int DEC_W         = DECAY_BITS + 4;
  localparam int MS_W          = 10;
  localparam int RATE_W        = 16;
  localparam int MS_PROD_W     = MS_W + RATE_W;
  localparam int MUL_A_W       = (FRAC_W > MS_W) ? FRAC_W : MS_W;
  localparam int MUL_B_W       = 16;
  localparam int PROD_W        = MUL_A_W + MUL_B_W;
  localparam int CNT_W         = $clog2(FRACTION_BITS + 1);
  localparam int LVL_W         = 16;
  localparam int PX_W          = 12;
  localparam int COL_W         = 8;

  localparam logic [FRAC_W-1:0] ONE_FIX  = FRAC_W'(1) << FRACTION_BITS;
  localparam logic [FRAC_W-1:0] HALF_FIX = FRAC_W'(1) << (FRACTION_BITS - 1);
  localparam logic [FRAC_W-1:0] C02_FIX  = FRAC_W'(((64'd1 << FRACTION_BITS) + 64'd2) / 64'd5);
  localparam logic [PROD_W:0]   C03_FIX  = (PROD_W + 1)'(153) << (FRACTION_BITS - 1);

  // configuration register indexes
  localparam logic [2:0] REG_HOLD_TIME  = 3'd0;
  localparam logic [2:0] REG_DECAY_RATE = 3'd1;
  localparam logic [2:0] REG_BAR_LEFT   = 3'd2;
  localparam logic [2:0] REG_BAR_WIDTH  = 3'd3;
  localparam logic [2:0] REG_BASE_RED   = 3'd4;
  localparam logic [2:0] REG_BASE_GREEN = 3'd5;
  localparam logic [2:0] REG_BASE_BLUE  = 3'd6;

  // multiplier operand selects
  localparam logic [2:0] MS_NONE = 3'd0;
  localparam logic [2:0] MS_FW   = 3'd1;
  localparam logic [2:0] MS_C1   = 3'd2;
  localparam logic [2:0] MS_C2   = 3'd3;
  localparam logic [2:0] MS_DEC  = 3'd4;
  localparam logic [2:0] MS_GW   = 3'd5;

  // product consumers
  localparam logic [1:0] WD_NONE = 2'd0;
  localparam logic [1:0] WD_LW   = 2'd1;
  localparam logic [1:0] WD_C1   = 2'd2;
  localparam logic [1:0] WD_C2   = 2'd3;

  // jump conditions
  localparam logic [1:0] JC_NEXT = 2'd0;
  localparam logic [1:0] JC_LOOP = 2'd1;
  localparam logic [1:0] JC_DONE = 2'd2;

  // program steps
  localparam logic [3:0] ST_DIV   = 4'd0;
  localparam logic [3:0] ST_FIX   = 4'd1;
  localparam logic [3:0] ST_MLW   = 4'd2;
  localparam logic [3:0] ST_MC1   = 4'd3;
  localparam logic [3:0] ST_MC2   = 4'd4;
  localparam logic [3:0] ST_MDEC  = 4'd5;
  localparam logic [3:0] ST_TRAIL = 4'd6;
  localparam logic [3:0] ST_MGW   = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  typedef struct packed {
    logic [2:0] mul_sel;
    logic [1:0] wr_sel;
    logic       div_en;
    logic       fix_en;
    logic       trail_en;
    logic       out_en;
    logic [1:0] jc;
    logic [3:0] tgt;
  } uword_t;

  function automatic uword_t ucode_rom(input logic [3:0] pc);
    uword_t w;
    w = '{mul_sel: MS_NONE, wr_sel: WD_NONE, div_en: 1'b0, fix_en: 1'b0,
          trail_en: 1'b0, out_en: 1'b0, jc: JC_NEXT, tgt: ST_DIV};
    case (pc)
      ST_DIV: begin
        w.div_en = 1'b1;
        w.jc     = JC_LOOP;
        w.tgt    = ST_DIV;
      end
      ST_FIX:   w.fix_en = 1'b1;
      ST_MLW:   w.mul_sel = MS_FW;
      ST_MC1: begin
        w.mul_sel = MS_C1;
        w.wr_sel  = WD_LW;
      end
      ST_MC2: begin
        w.mul_sel = MS_C2;
        w.wr_sel  = WD_C1;
      end
      ST_MDEC: begin
        w.mul_sel = MS_DEC;
        w.wr_sel  = WD_C2;
      end
      ST_TRAIL: w.trail_en = 1'b1;
      ST_MGW:   w.mul_sel = MS_GW;
      ST_OUT: begin
        w.out_en = 1'b1;
        w.jc     = JC_DONE;
      end
      default: w.jc = JC_DONE;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/level_bar_peak_hold_decay_unit.sv =====
// level bar with peak hold and decay
// input channel: in_valid/in_stall with level, level_max, source_id, frame_ms;
// one request gives exactly one result on out_valid/out_stall.
// configuration: cfg_we writes cfg_wdata into register cfg_index (0 hold
// time, 1 decay rate, 2 bar left, 3 bar width, 4..6 base red/green/blue);
// write only while the block is idle.
// a small microcode program steps one datapath: a restoring divider that
// makes one quotient bit per cycle, then eight steps, five of which share
// one multiplier for the pixel spans, colors and decay.
// in_stall is high while an item is being worked on; a new item may be
// taken while the previous result still waits in the output register.
// if the receiver stalls, the finished item waits in its last step and the
// output register holds its result unchanged.
// reset (synchronous, rst_n low) empties the block, loads register defaults,
// clears the trailing value and hold time and marks no source as tracked.
module level_bar_peak_hold_decay_unit
  import lvb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [LVL_W-1:0]  in_level,
  input  logic signed [LVL_W-1:0]  in_level_max,
  input  logic        [5:0]        in_source_id,
  input  logic        [MS_W-1:0]   in_frame_ms,
  input  logic                     cfg_we,
  input  logic        [2:0]        cfg_index,
  input  logic        [15:0]       cfg_wdata,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic        [FRAC_W-1:0] out_live_frac,
  output logic                     out_live_draw,
  output logic        [PX_W-1:0]   out_live_width_px,
  output logic        [COL_W-1:0]  out_live_red,
  output logic        [COL_W-1:0]  out_live_green,
  output logic        [COL_W-1:0]  out_live_blue,
  output logic                     out_ghost_draw,
  output logic        [FRAC_W-1:0] out_ghost_frac,
  output logic        [PX_W:0]     out_ghost_x_px,
  output logic        [PX_W-1:0]   out_ghost_width_px
);

  // configuration
  logic [15:0]       hold_time_r;
  logic [RATE_W-1:0] decay_rate_r;
  logic [PX_W-1:0]   bar_left_r;
  logic [PX_W-1:0]   bar_width_r;
  logic [COL_W-1:0]  base_red_r;
  logic [COL_W-1:0]  base_green_r;
  logic [COL_W-1:0]  base_blue_r;

  // tracking state
  logic [FRAC_W-1:0] trail_r, trail_nxt;
  logic [6:0]        last_src_r, last_src_nxt;
  logic [15:0]       hold_left_r, hold_left_nxt;

  // sequencer
  logic              busy_r;
  logic [3:0]        pc_r, pc_nxt;
  logic [CNT_W-1:0]  cnt_r;
  uword_t            uw;

  // per-item datapath
  logic [LVL_W-1:0]          am_r;
  logic [LVL_W-1:0]          rem_r;
  logic [FRACTION_BITS-1:0]  q_r;
  logic                      zero_r;
  logic                      one_r;
  logic [5:0]                src_r;
  logic [MS_W-1:0]           ms_r;
  logic [FRAC_W-1:0]         f_r;
  logic [PROD_W-1:0]         prod_r;
  logic [PX_W-1:0]           live_w_r;
  logic [COL_W-1:0]          red_r, green_r, blue_r;
  logic                      ghost_r;

  // output register
  logic              out_valid_r;
  logic [FRAC_W-1:0] o_live_frac_r;
  logic              o_live_draw_r;
  logic [PX_W-1:0]   o_live_w_r;
  logic [COL_W-1:0]  o_red_r, o_green_r, o_blue_r;
  logic              o_ghost_draw_r;
  logic [FRAC_W-1:0] o_ghost_frac_r;
  logic [PX_W:0]     o_ghost_x_r;
  logic [PX_W-1:0]   o_ghost_w_r;

  logic in_acc;
  logic out_held;
  logic finish;

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign out_held = out_valid_r && out_stall;
  assign uw       = ucode_rom(pc_r);
  assign finish   = busy_r && uw.out_en && !out_held;

  // magnitudes and the special cases of the live fraction
  logic [LVL_W-1:0] al_in, am_in;
  logic             zero_in;

  always_comb begin
    al_in   = in_level[LVL_W-1] ? (~in_level + 1'b1) : in_level;
    am_in   = in_level_max[LVL_W-1] ? (~in_level_max + 1'b1) : in_level_max;
    zero_in = (al_in == '0) || (am_in == '0) ||
              (in_level[LVL_W-1] != in_level_max[LVL_W-1]);
  end

  // one restoring divide step
  logic [LVL_W:0]   rem2;
  logic             q_bit;
  logic [LVL_W-1:0] rem_step;

  always_comb begin
    rem2     = {rem_r, 1'b0};
    q_bit    = rem2 >= {1'b0, am_r};
    rem_step = q_bit ? LVL_W'(rem2 - {1'b0, am_r}) : rem2[LVL_W-1:0];
  end

  // shared multiplier
  logic              fade;
  logic [FRAC_W-1:0] two_t;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_nxt;

  always_comb begin
    fade  = f_r > HALF_FIX;
    two_t = FRAC_W'((ONE_FIX - f_r) << 1);
    mul_a = '0;
    mul_b = '0;
    case (uw.mul_sel)
      MS_FW: begin
        mul_a = MUL_A_W'(f_r);
        mul_b = MUL_B_W'(bar_width_r);
      end
      MS_C1: begin
        if (fade) begin
          mul_a = MUL_A_W'(two_t);
          mul_b = MUL_B_W'(base_red_r);
        end else begin
          mul_a = MUL_A_W'(FRAC_W'(f_r + C02_FIX));
          mul_b = MUL_B_W'(base_green_r);
        end
      end
      MS_C2: begin
        mul_a = MUL_A_W'(two_t);
        mul_b = MUL_B_W'(base_blue_r);
      end
      MS_DEC: begin
        mul_a = MUL_A_W'(ms_r);
        mul_b = MUL_B_W'(decay_rate_r);
      end
      MS_GW: begin
        mul_a = MUL_A_W'(FRAC_W'(trail_r - f_r));
        mul_b = MUL_B_W'(bar_width_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // boost rule for green
  logic [PROD_W:0]  gsum;
  logic [COL_W-1:0] green_boost;

  always_comb begin
    gsum        = (PROD_W + 1)'(prod_r) + C03_FIX;
    green_boost = (gsum[PROD_W:FRACTION_BITS] > (PROD_W + 1 - FRACTION_BITS)'(255)) ?
                  COL_W'(255) : gsum[FRACTION_BITS+COL_W-1:FRACTION_BITS];
  end

  // trailing value update
  logic signed [DEC_W-1:0] t24, f24, n24;

  always_comb begin
    t24           = DEC_W'(trail_r) << DEC_SHIFT;
    f24           = DEC_W'(f_r) << DEC_SHIFT;
    n24           = t24 - DEC_W'(prod_r[MS_PROD_W-1:0]);
    trail_nxt     = trail_r;
    last_src_nxt  = last_src_r;
    hold_left_nxt = hold_left_r;
    if ({1'b0, src_r} != last_src_r) begin
      trail_nxt     = f_r;
      last_src_nxt  = {1'b0, src_r};
      hold_left_nxt = hold_time_r;
    end else if (f_r >= trail_r) begin
      trail_nxt     = f_r;
      hold_left_nxt = hold_time_r;
    end else if (hold_left_r != '0) begin
      hold_left_nxt = (hold_left_r > 16'(ms_r)) ? hold_left_r - 16'(ms_r) : '0;
    end else if (n24 <= f24) begin
      trail_nxt     = f_r;
      hold_left_nxt = hold_time_r;
    end else begin
      trail_nxt = n24[DEC_SHIFT+FRAC_W-1:DEC_SHIFT];
    end
  end

  // step counter
  always_comb begin
    pc_nxt = pc_r;
    if (busy_r) begin
      case (uw.jc)
        JC_NEXT: pc_nxt = pc_r + 4'd1;
        JC_LOOP: pc_nxt = (cnt_r != CNT_W'(1)) ? uw.tgt : pc_r + 4'd1;
        JC_DONE: pc_nxt = out_held ? pc_r : ST_DIV;
        default: pc_nxt = ST_DIV;
      endcase
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pc_r         <= ST_DIV;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      trail_r      <= '0;
      last_src_r   <= 7'd127;
      hold_left_r  <= '0;
      hold_time_r  <= '0;
      decay_rate_r <= RATE_W'(20133);
      bar_left_r   <= '0;
      bar_width_r  <= '0;
      base_red_r   <= COL_W'(255);
      base_green_r <= COL_W'(255);
      base_blue_r  <= COL_W'(255);
    end else begin
      pc_r <= pc_nxt;
      if (in_acc) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(FRACTION_BITS);
      end else if (finish) begin
        busy_r <= 1'b0;
      end
      if (busy_r && uw.div_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (busy_r && uw.trail_en) begin
        trail_r     <= trail_nxt;
        last_src_r  <= last_src_nxt;
        hold_left_r <= hold_left_nxt;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_HOLD_TIME:  hold_time_r  <= cfg_wdata;
          REG_DECAY_RATE: decay_rate_r <= cfg_wdata;
          REG_BAR_LEFT:   bar_left_r   <= cfg_wdata[PX_W-1:0];
          REG_BAR_WIDTH:  bar_width_r  <= cfg_wdata[PX_W-1:0];
          REG_BASE_RED:   base_red_r   <= cfg_wdata[COL_W-1:0];
          REG_BASE_GREEN: base_green_r <= cfg_wdata[COL_W-1:0];
          REG_BASE_BLUE:  base_blue_r  <= cfg_wdata[COL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      am_r   <= am_in;
      rem_r  <= al_in;
      zero_r <= zero_in;
      one_r  <= al_in >= am_in;
      src_r  <= in_source_id;
      ms_r   <= in_frame_ms;
    end
    if (busy_r && uw.div_en) begin
      rem_r <= rem_step;
      q_r   <= {q_r[FRACTION_BITS-2:0], q_bit};
    end
    if (busy_r && uw.fix_en) begin
      f_r <= zero_r ? '0 : (one_r ? ONE_FIX : FRAC_W'(q_r));
    end
    if (busy_r && (uw.mul_sel != MS_NONE)) begin
      prod_r <= prod_nxt;
    end
    if (busy_r) begin
      case (uw.wr_sel)
        WD_LW: live_w_r <= prod_r[FRACTION_BITS+PX_W-1:FRACTION_BITS];
        WD_C1: begin
          if (fade) begin
            red_r   <= prod_r[FRACTION_BITS+COL_W-1:FRACTION_BITS];
            green_r <= base_green_r;
          end else begin
            red_r   <= base_red_r;
            green_r <= green_boost;
            blue_r  <= base_blue_r;
          end
        end
        WD_C2: begin
          if (fade) begin
            blue_r <= prod_r[FRACTION_BITS+COL_W-1:FRACTION_BITS];
          end
        end
        default: ;
      endcase
    end
    if (busy_r && uw.trail_en) begin
      ghost_r <= trail_nxt > f_r;
    end
    if (finish) begin
      o_live_frac_r  <= f_r;
      o_live_draw_r  <= f_r != '0;
      o_live_w_r     <= live_w_r;
      o_red_r        <= (f_r != '0) ? red_r : '0;
      o_green_r      <= (f_r != '0) ? green_r : '0;
      o_blue_r       <= (f_r != '0) ? blue_r : '0;
      o_ghost_draw_r <= ghost_r;
      o_ghost_frac_r <= trail_r;
      o_ghost_x_r    <= ghost_r ? ({1'b0, bar_left_r} + {1'b0, live_w_r}) : '0;
      o_ghost_w_r    <= ghost_r ? prod_r[FRACTION_BITS+PX_W-1:FRACTION_BITS] : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_live_frac      = o_live_frac_r;
  assign out_live_draw      = o_live_draw_r;
  assign out_live_width_px  = o_live_w_r;
  assign out_live_red       = o_red_r;
  assign out_live_green     = o_green_r;
  assign out_live_blue      = o_blue_r;
  assign out_ghost_draw     = o_ghost_draw_r;
  assign out_ghost_frac     = o_ghost_frac_r;
  assign out_ghost_x_px     = o_ghost_x_r;
  assign out_ghost_width_px = o_ghost_w_r;

`ifndef SYNTHESIS
  a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (pc_r == ST_DIV))
    else $error("sequencer left its first step while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r && (pc_r == ST_DIV))
    else $error("accepted request did not start the program");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r) && !busy_r)
    else $error("result appeared without finishing a request");

  a_live_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_live_draw_r == (o_live_frac_r != '0)))
    else $error("live draw flag disagrees with live fraction");

  a_ghost_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_ghost_draw_r |-> (o_ghost_frac_r > o_live_frac_r))
    else $error("ghost drawn below live fraction");
`endif

endmodule
